FILE: hw/rtl/fdit_pkg.sv
// fdit_pkg: shared types and constants of the dual interval timer.
// Command codes, register indexes, prescaler sizing and the slow-tick divide.
// No dependencies.
package fdit_pkg;

	localparam int SLOW_TICK_DIVIDE = 4;
	localparam int PRESCALE_W = (SLOW_TICK_DIVIDE > 1) ? $clog2(SLOW_TICK_DIVIDE) : 1;
	localparam logic [PRESCALE_W-1:0] PRESCALE_LAST = PRESCALE_W'(SLOW_TICK_DIVIDE - 1);

	typedef enum logic [1:0] {
		CMD_WRITE    = 2'd0,
		CMD_STATUS   = 2'd1,
		CMD_READBACK = 2'd2,
		CMD_TICK     = 2'd3
	} cmd_t;

	localparam logic [7:0] REG_FAST_PRESET = 8'h02;
	localparam logic [7:0] REG_SLOW_PRESET = 8'h03;
	localparam logic [7:0] REG_CONTROL     = 8'h04;

	localparam int CTRL_CLEAR_BIT     = 7;
	localparam int CTRL_FAST_MASK_BIT = 6;
	localparam int CTRL_SLOW_MASK_BIT = 5;
	localparam int CTRL_SLOW_RUN_BIT  = 1;
	localparam int CTRL_FAST_RUN_BIT  = 0;

	localparam logic [7:0] COUNT_MAX = 8'hFF;

	// bit 0 of each flag pair is the fast timer, bit 1 the slow timer
	typedef struct packed {
		logic slow;
		logic fast;
	} timer_pair_t;

endpackage

FILE: hw/rtl/fm_chip_dual_interval_timer_unit.sv
// fm_chip_dual_interval_timer_unit: top level of the dual interval timer.
// Depends on fdit_pkg.
//
// Two 8-bit preset timers behind registers 2, 3 and 4. Each request is a
// register write, a status read, a readback or one base tick; each gives one
// result (read_data, claimed). A request is taken into an input register and
// then executed from there into the result register; one request per clock
// is sustained while out_stall is low. The only throttle is out_stall, which
// holds the result register and then the input register. Timer 1 counts on
// every fourth base tick.
module fm_chip_dual_interval_timer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] command,
	input  logic [7:0] reg_index,
	input  logic [7:0] write_data,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_data,
	output logic       claimed
);
	import fdit_pkg::*;

	logic                  valid_s1;
	cmd_t                  command_s1;
	logic [7:0]            reg_index_s1;
	logic [7:0]            write_data_s1;

	logic                  low_bits_six_q;
	logic [7:0]            fast_preset_q, slow_preset_q;
	logic [7:0]            fast_count_q, slow_count_q;
	timer_pair_t           run_q, mask_q, ovf_q;
	logic [PRESCALE_W-1:0] tick_prescale_q;

	logic                  out_valid_q;
	logic [7:0]            read_data_q;
	logic                  claimed_q;

	logic [7:0]            fast_preset_n, slow_preset_n;
	logic [7:0]            fast_count_n, slow_count_n;
	timer_pair_t           run_n, mask_n, ovf_n;
	logic [PRESCALE_W-1:0] tick_prescale_n;
	logic [7:0]            data_n;
	logic                  claimed_n;
	logic                  slow_tick;
	logic                  advance;

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	always_comb begin
		fast_preset_n   = fast_preset_q;
		slow_preset_n   = slow_preset_q;
		fast_count_n    = fast_count_q;
		slow_count_n    = slow_count_q;
		run_n           = run_q;
		mask_n          = mask_q;
		ovf_n           = ovf_q;
		tick_prescale_n = tick_prescale_q;
		claimed_n       = 1'b0;
		slow_tick       = 1'b0;
		data_n          = 8'h00;

		case (command_s1)
			CMD_WRITE: begin
				case (reg_index_s1)
					REG_FAST_PRESET: begin
						fast_preset_n = write_data_s1;
						claimed_n     = 1'b1;
					end
					REG_SLOW_PRESET: begin
						slow_preset_n = write_data_s1;
						claimed_n     = 1'b1;
					end
					REG_CONTROL: begin
						claimed_n = 1'b1;
						if (write_data_s1[CTRL_CLEAR_BIT]) begin
							ovf_n = '0;
						end else begin
							if (write_data_s1[CTRL_FAST_RUN_BIT]) begin
								if (!run_q.fast) begin
									run_n.fast   = 1'b1;
									ovf_n.fast   = 1'b0;
									fast_count_n = fast_preset_q;
								end
							end else begin
								run_n.fast = 1'b0;
							end
							if (write_data_s1[CTRL_SLOW_RUN_BIT]) begin
								if (!run_q.slow) begin
									run_n.slow   = 1'b1;
									ovf_n.slow   = 1'b0;
									slow_count_n = slow_preset_q;
								end
							end else begin
								run_n.slow = 1'b0;
							end
							mask_n.fast = write_data_s1[CTRL_FAST_MASK_BIT];
							mask_n.slow = write_data_s1[CTRL_SLOW_MASK_BIT];
							ovf_n       = ovf_n & ~mask_n;
						end
					end
					default: claimed_n = 1'b0;
				endcase
			end
			CMD_TICK: begin
				if (tick_prescale_q == PRESCALE_LAST) begin
					tick_prescale_n = '0;
					slow_tick       = 1'b1;
				end else begin
					tick_prescale_n = tick_prescale_q + 1'b1;
				end
				if (run_q.fast) begin
					if (fast_count_q == COUNT_MAX) begin
						fast_count_n = fast_preset_q;
						if (!mask_q.fast) ovf_n.fast = 1'b1;
					end else begin
						fast_count_n = fast_count_q + 8'd1;
					end
				end
				if (slow_tick && run_q.slow) begin
					if (slow_count_q == COUNT_MAX) begin
						slow_count_n = slow_preset_q;
						if (!mask_q.slow) ovf_n.slow = 1'b1;
					end else begin
						slow_count_n = slow_count_q + 8'd1;
					end
				end
			end
			default: ;
		endcase

		if (command_s1 == CMD_READBACK) begin
			case (reg_index_s1)
				REG_FAST_PRESET: data_n = fast_preset_q;
				REG_SLOW_PRESET: data_n = slow_preset_q;
				REG_CONTROL:     data_n = {1'b0, mask_q.fast, mask_q.slow, 3'b000,
							run_q.slow, run_q.fast};
				default:         data_n = 8'h00;
			endcase
		end else begin
			data_n = {ovf_n.fast | ovf_n.slow, ovf_n.fast, ovf_n.slow, 2'b00,
				low_bits_six_q, low_bits_six_q, 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			command_s1    <= cmd_t'(command);
			reg_index_s1  <= reg_index;
			write_data_s1 <= write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_bits_six_q  <= 1'b0;
			fast_preset_q   <= '0;
			slow_preset_q   <= '0;
			fast_count_q    <= '0;
			slow_count_q    <= '0;
			run_q           <= '0;
			mask_q          <= '0;
			ovf_q           <= '0;
			tick_prescale_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) low_bits_six_q <= cfg_data;
			if (advance) begin
				fast_preset_q   <= fast_preset_n;
				slow_preset_q   <= slow_preset_n;
				fast_count_q    <= fast_count_n;
				slow_count_q    <= slow_count_n;
				run_q           <= run_n;
				mask_q          <= mask_n;
				ovf_q           <= ovf_n;
				tick_prescale_q <= tick_prescale_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= data_n;
			claimed_q   <= claimed_n;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign claimed   = claimed_q;

endmodule

FILE: hw/rtl/fdit_checker.sv
// fdit_checker: port-level assertions for the dual interval timer, and the
// bind that attaches them to fm_chip_dual_interval_timer_unit.
// No package dependency.
module fdit_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] read_data,
	input logic       claimed
);

	// a held result stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(read_data) && $stable(claimed))
		else $error("stalled result changed");

	// input side only backs up behind a full, stalled result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with output free");

	// a claimed write returns a well-formed status byte
	a_claim_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && claimed |-> read_data[0] == 1'b0 && read_data[4:3] == 2'b00
			&& read_data[7] == (read_data[6] | read_data[5])
			&& read_data[2] == read_data[1])
		else $error("claimed write without status byte");

endmodule

bind fm_chip_dual_interval_timer_unit fdit_checker u_fdit_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.read_data (read_data),
	.claimed   (claimed)
);

FILE: dv/tb_fm_chip_dual_interval_timer_unit.sv
// Testbench for fm_chip_dual_interval_timer_unit: directed request table, then random phases.
// Replies from a behavioural model of both timers (fixed rows: table), checked in order.
// Depends on fdit_pkg and the timer RTL.
module tb_fm_chip_dual_interval_timer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import fdit_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] idx;
		logic [7:0] data;
	} request_t;

	typedef struct packed {
		logic [7:0] rd;
		logic       clm;
	} reply_t;

	typedef struct packed {
		request_t req;
		logic     fixed;
		reply_t   reply;
	} table_row_t;

	localparam table_row_t DIRECTED [0:25] = '{
		'{'{CMD_STATUS,   8'h00, 8'h00}, 1'b1, '{8'h00, 1'b0}},
		'{'{CMD_READBACK, 8'h04, 8'h00}, 1'b1, '{8'h00, 1'b0}},
		'{'{CMD_READBACK, 8'h02, 8'h00}, 1'b1, '{8'h00, 1'b0}},
		'{'{CMD_WRITE,    8'h02, 8'hFE}, 1'b1, '{8'h00, 1'b1}},
		'{'{CMD_WRITE,    8'h03, 8'hFF}, 1'b1, '{8'h00, 1'b1}},
		'{'{CMD_READBACK, 8'h02, 8'h00}, 1'b1, '{8'hFE, 1'b0}},
		'{'{CMD_READBACK, 8'h03, 8'h00}, 1'b1, '{8'hFF, 1'b0}},
		'{'{CMD_WRITE,    8'h00, 8'hFF}, 1'b1, '{8'h00, 1'b0}},
		'{'{CMD_WRITE,    8'hFF, 8'h55}, 1'b1, '{8'h00, 1'b0}},
		'{'{CMD_READBACK, 8'hFF, 8'hAA}, 1'b1, '{8'h00, 1'b0}},
		'{'{CMD_WRITE,    8'h04, 8'h03}, 1'b0, '{8'h00, 1'b0}},
		'{'{CMD_TICK,     8'h00, 8'h00}, 1'b0, '{8'h00, 1'b0}},
		'{'{CMD_TICK,     8'hFF, 8'hFF}, 1'b0, '{8'h00, 1'b0}},
		'{'{CMD_TICK,     8'h00, 8'h00}, 1'b0, '{8'h00, 1'b0}},
		'{'{CMD_TICK,     8'h00, 8'h00}, 1'b0, '{8'h00, 1'b0}},
		'{'{CMD_WRITE,    8'h04, 8'h03}, 1'b0, '{8'h00, 1'b0}},
		'{'{CMD_WRITE,    8'h04, 8'h43}, 1'b0, '{8'h00, 1'b0}},
		'{'{CMD_READBACK, 8'h04, 8'h00}, 1'b0, '{8'h00, 1'b0}},
		'{'{CMD_WRITE,    8'h04, 8'h80}, 1'b1, '{8'h00, 1'b1}},
		'{'{CMD_WRITE,    8'h04, 8'h00}, 1'b0, '{8'h00, 1'b0}},
		'{'{CMD_TICK,     8'h00, 8'h00}, 1'b0, '{8'h00, 1'b0}},
		'{'{CMD_WRITE,    8'h02, 8'h10}, 1'b0, '{8'h00, 1'b0}},
		'{'{CMD_WRITE,    8'h04, 8'h23}, 1'b0, '{8'h00, 1'b0}},
		'{'{CMD_WRITE,    8'h02, 8'hFF}, 1'b0, '{8'h00, 1'b0}},
		'{'{CMD_STATUS,   8'h00, 8'h00}, 1'b0, '{8'h00, 1'b0}},
		'{'{CMD_READBACK, 8'h04, 8'h00}, 1'b0, '{8'h00, 1'b0}}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_data = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] command = CMD_STATUS;
	logic [7:0] reg_index = 8'h00;
	logic [7:0] write_data = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] read_data;
	logic       claimed;

	// timer model state
	logic [7:0]            fast_preset, slow_preset, fast_count, slow_count;
	timer_pair_t           run_bits, mask_bits, ovf_bits;
	logic [PRESCALE_W-1:0] prescale;
	logic                  legacy_status;

	reply_t      bus_replies [$];
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	int unsigned calm_items = 0;
	int unsigned stall_left = 0;
	int unsigned calm_left = 0;
	int unsigned stall_roll;
	request_t    rand_req;

	fm_chip_dual_interval_timer_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.reg_index  (reg_index),
		.write_data (write_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_data  (read_data),
		.claimed    (claimed)
	);

	always #10 clk = ~clk;

	function automatic logic [7:0] status_byte();
		return {ovf_bits.fast | ovf_bits.slow, ovf_bits.fast, ovf_bits.slow, 2'b00,
			legacy_status, legacy_status, 1'b0};
	endfunction

	function automatic logic [7:0] counted(input logic [7:0] cnt, input logic [7:0] pre,
			input logic running, input logic masked, output logic wrapped);
		wrapped = 1'b0;
		if (!running)
			return cnt;
		if (cnt == COUNT_MAX) begin
			wrapped = !masked;
			return pre;
		end
		return cnt + 8'd1;
	endfunction

	function automatic reply_t apply_request(input request_t req);
		reply_t r;
		logic   wrap;
		logic   slow_due;
		logic   fast_on, slow_on;
		r.clm = 1'b0;
		r.rd = 8'h00;
		case (req.cmd)
			CMD_WRITE: begin
				r.clm = 1'b1;
				case (req.idx)
					REG_FAST_PRESET: fast_preset = req.data;
					REG_SLOW_PRESET: slow_preset = req.data;
					REG_CONTROL: begin
						if (req.data[CTRL_CLEAR_BIT]) begin
							ovf_bits = '0;
						end else begin
							fast_on = req.data[CTRL_FAST_RUN_BIT];
							slow_on = req.data[CTRL_SLOW_RUN_BIT];
							if (fast_on && !run_bits.fast) begin
								ovf_bits.fast = 1'b0;
								fast_count = fast_preset;
							end
							if (slow_on && !run_bits.slow) begin
								ovf_bits.slow = 1'b0;
								slow_count = slow_preset;
							end
							run_bits.fast = fast_on;
							run_bits.slow = slow_on;
							mask_bits.fast = req.data[CTRL_FAST_MASK_BIT];
							mask_bits.slow = req.data[CTRL_SLOW_MASK_BIT];
							ovf_bits = ovf_bits & ~mask_bits;
						end
					end
					default: r.clm = 1'b0;
				endcase
				r.rd = status_byte();
			end
			CMD_READBACK: begin
				case (req.idx)
					REG_FAST_PRESET: r.rd = fast_preset;
					REG_SLOW_PRESET: r.rd = slow_preset;
					REG_CONTROL: r.rd = {1'b0, mask_bits.fast, mask_bits.slow, 3'b000,
						run_bits.slow, run_bits.fast};
					default: r.rd = 8'h00;
				endcase
			end
			CMD_TICK: begin
				slow_due = (prescale == PRESCALE_LAST);
				prescale = slow_due ? '0 : prescale + 1'b1;
				fast_count = counted(fast_count, fast_preset, run_bits.fast, mask_bits.fast, wrap);
				if (wrap)
					ovf_bits.fast = 1'b1;
				if (slow_due) begin
					slow_count = counted(slow_count, slow_preset, run_bits.slow, mask_bits.slow,
						wrap);
					if (wrap)
						ovf_bits.slow = 1'b1;
				end
				r.rd = status_byte();
			end
			default: r.rd = status_byte();
		endcase
		return r;
	endfunction

	function automatic int unsigned sender_gap();
		int unsigned roll;
		if (calm_items != 0) begin
			calm_items--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 4) begin
			calm_items = $urandom_range(20, 50);
			return 0;
		end
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] preset_value();
		if ($urandom_range(0, 3) != 0)
			return 8'($urandom_range(200, 255));
		return 8'($urandom_range(0, 255));
	endfunction

	// mostly ticks and control/preset writes so that overflows actually happen
	function automatic request_t random_request();
		request_t    req;
		int unsigned roll, pick;
		roll = $urandom_range(0, 99);
		req.idx = 8'($urandom_range(0, 255));
		req.data = 8'($urandom_range(0, 255));
		if (roll < 45) begin
			req.cmd = CMD_TICK;
		end else if (roll < 55) begin
			req.cmd = CMD_STATUS;
		end else if (roll < 65) begin
			req.cmd = CMD_READBACK;
			pick = $urandom_range(0, 9);
			if (pick < 8)
				req.idx = (pick < 3) ? REG_FAST_PRESET : (pick < 5) ? REG_SLOW_PRESET : REG_CONTROL;
		end else begin
			req.cmd = CMD_WRITE;
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				req.idx = REG_CONTROL;
				if ($urandom_range(0, 3) != 0)
					req.data[CTRL_CLEAR_BIT] = 1'b0;
				if ($urandom_range(0, 9) < 6) begin
					req.data[CTRL_FAST_RUN_BIT] = 1'b1;
					req.data[CTRL_SLOW_RUN_BIT] = 1'b1;
				end
			end else if (pick < 65) begin
				req.idx = REG_FAST_PRESET;
				req.data = preset_value();
			end else if (pick < 85) begin
				req.idx = REG_SLOW_PRESET;
				req.data = preset_value();
			end
		end
		return req;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic send_request(input request_t req, input logic fixed, input reply_t want);
		int unsigned gap;
		reply_t      pred;
		gap = sender_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= req.cmd;
		reg_index <= req.idx;
		write_data <= req.data;
		do @(posedge clk); while (in_stall);
		pred = apply_request(req);
		bus_replies.push_back(fixed ? want : pred);
	endtask

	task automatic drain_replies();
		in_valid <= 1'b0;
		while (bus_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_status_mode(input logic value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		legacy_status = value;
	endtask

	always @(posedge clk) begin
		if (calm_left != 0) begin
			calm_left <= calm_left - 1;
			out_stall <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else begin
			stall_roll = $urandom_range(0, 99);
			if (stall_roll < 3) begin
				calm_left <= $urandom_range(30, 90);
				out_stall <= 1'b0;
			end else if (stall_roll < 65) begin
				out_stall <= 1'b0;
			end else if (stall_roll < 95) begin
				out_stall <= 1'b1;
			end else begin
				stall_left <= $urandom_range(8, 40);
				out_stall <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (bus_replies.size() == 0) begin
				report_mismatch("reply with nothing outstanding", read_data, 0);
			end else begin
				if (read_data !== bus_replies[0].rd)
					report_mismatch("read_data", read_data, bus_replies[0].rd);
				if (claimed !== bus_replies[0].clm)
					report_mismatch("claimed", claimed, bus_replies[0].clm);
				void'(bus_replies.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		fast_preset = '0;
		slow_preset = '0;
		fast_count = '0;
		slow_count = '0;
		run_bits = '0;
		mask_bits = '0;
		ovf_bits = '0;
		prescale = '0;
		legacy_status = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_status_mode(1'b0);
		foreach (DIRECTED[i])
			send_request(DIRECTED[i].req, DIRECTED[i].fixed, DIRECTED[i].reply);
		for (int phase = 0; phase < 4; phase++) begin
			drain_replies();
			write_status_mode(!phase[0]);
			repeat (100) begin
				rand_req = random_request();
				send_request(rand_req, 1'b0, '0);
				if ($urandom_range(0, 99) == 0)
					drain_replies();
			end
		end
		drain_replies();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/fdit_pkg.sv
hw/rtl/fm_chip_dual_interval_timer_unit.sv
hw/rtl/fdit_checker.sv
dv/tb_fm_chip_dual_interval_timer_unit.sv
